FILE: rtl/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg: shared types and constants for the searchable ring fifo
// Store depth, derived widths, command and status codes, and the control
// bundle that the sequencer hands to the row of storage cells.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int DEPTH   = 128;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CODE_W  = 8;
  localparam int COUNT_W = 8;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // shift moves every cell one place towards the head (pop and scan rotate)
  typedef struct packed {
    logic             shift;
    logic             push;
    logic [IDX_W-1:0] wr_idx;
  } ring_ctl_t;

endpackage

FILE: rtl/searchable_ring_fifo.sv
// ----------------------------------------------------------------------------
// searchable_ring_fifo: fifo of event codes with a membership search
// Push, pop and clear each give a registered result beat that shows the
// cycle after the input beat. A query rotates the cell row once past one
// comparator at the head cell; input stalls for the scan and the result
// beat is registered when it ends. Oldest entry sits in cell 0 whenever no
// scan runs. Reset empties the store; cell contents are not cleared.
// ----------------------------------------------------------------------------
module searchable_ring_fifo
  import srf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [CODE_W-1:0]  code_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [CODE_W-1:0]  code_out,
  output logic               found,
  output logic [COUNT_W-1:0] count
);

  ring_ctl_t         ctl;
  logic [CODE_W-1:0] ring_q [DEPTH];

  srf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .code_in   (code_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .code_out  (code_out),
    .found     (found),
    .count     (count),
    .head_q    (ring_q[0]),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % DEPTH;

    srf_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .wr    (ctl.push && (ctl.wr_idx == IDX_W'(i))),
      .din   (code_in),
      .nbr   (ring_q[NXT]),
      .q     (ring_q[i])
    );
  end

endmodule

FILE: rtl/srf_cell.sv
// ----------------------------------------------------------------------------
// srf_cell: one storage cell of the ring
// Holds one event code; on a shift it takes its neighbour's code, otherwise
// it can be written with a pushed code.
// ----------------------------------------------------------------------------
module srf_cell
  import srf_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic              wr,
  input  logic [CODE_W-1:0] din,
  input  logic [CODE_W-1:0] nbr,
  output logic [CODE_W-1:0] q
);

  logic [CODE_W-1:0] data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= nbr;
    end else if (wr) begin
      data <= din;
    end
  end

  assign q = data;

endmodule

FILE: rtl/srf_ctrl.sv
// ----------------------------------------------------------------------------
// srf_ctrl: sequencer for the searchable ring fifo
// Takes input beats, keeps the occupancy, drives the cell row and walks the
// ring once past a single comparator at the head cell for a query.
// ----------------------------------------------------------------------------
module srf_ctrl
  import srf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [CODE_W-1:0]  code_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [CODE_W-1:0]  code_out,
  output logic               found,
  output logic [COUNT_W-1:0] count,
  input  logic [CODE_W-1:0]  head_q,
  output ring_ctl_t          ctl
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   occ, occ_next;
  logic [IDX_W-1:0]   step;
  logic [CODE_W-1:0]  key;
  logic               found_acc;
  logic               out_vld;
  status_t            status_reg;
  logic [CODE_W-1:0]  code_reg;
  logic               found_reg;
  logic [COUNT_W-1:0] count_reg;

  cmd_t    cmd;
  logic    acc;
  logic    take;
  logic    full;
  logic    empty;
  logic    hit;
  logic    scan_last;
  status_t stat_now;

  assign cmd       = cmd_t'(command);
  assign take      = out_vld && !out_stall;
  assign full      = (occ == CNT_W'(DEPTH));
  assign empty     = (occ == '0);
  assign acc       = in_valid && !in_stall;
  assign scan_last = (state == ST_SCAN) && (step == IDX_W'(DEPTH - 1));
  // only entries still waiting take part in the search
  assign hit       = (head_q == key) && (CNT_W'(step) < occ);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && cmd == CMD_QUERY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs to the handshake and the cell row
  always_comb begin
    in_stall   = 1'b1;
    ctl.shift  = 1'b0;
    ctl.push   = 1'b0;
    ctl.wr_idx = occ[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        in_stall  = out_vld && out_stall;
        ctl.shift = acc && (cmd == CMD_POP) && !empty;
        ctl.push  = acc && (cmd == CMD_PUSH) && !full;
      end
      ST_SCAN: begin
        ctl.shift = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    occ_next = occ;
    stat_now = STAT_OK;
    if (acc) begin
      case (cmd)
        CMD_PUSH: begin
          if (full) begin
            stat_now = STAT_FULL;
          end else begin
            occ_next = occ + 1'b1;
          end
        end
        CMD_POP: begin
          if (empty) begin
            stat_now = STAT_EMPTY;
          end else begin
            occ_next = occ - 1'b1;
          end
        end
        CMD_CLEAR: occ_next = '0;
        default:   occ_next = occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      occ     <= '0;
      out_vld <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if ((acc && cmd != CMD_QUERY) || scan_last) begin
        out_vld <= 1'b1;
      end else if (take) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      key       <= code_in;
      step      <= '0;
      found_acc <= 1'b0;
    end else if (state == ST_SCAN) begin
      step      <= step + 1'b1;
      found_acc <= found_acc | hit;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (acc && cmd != CMD_QUERY) begin
      status_reg <= stat_now;
      code_reg   <= (cmd == CMD_POP && !empty) ? head_q : '0;
      found_reg  <= 1'b0;
      count_reg  <= COUNT_W'(occ_next);
    end else if (scan_last) begin
      status_reg <= STAT_OK;
      code_reg   <= '0;
      found_reg  <= found_acc | hit;
      count_reg  <= COUNT_W'(occ);
    end
  end

  assign out_valid = out_vld;
  assign status    = status_reg;
  assign code_out  = code_reg;
  assign found     = found_reg;
  assign count     = count_reg;

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_no_push_on_shift: assert property (@(posedge clk) disable iff (rst)
    !(ctl.shift && ctl.push))
    else $error("push and shift together");

  a_query_scans: assert property (@(posedge clk) disable iff (rst)
    (acc && cmd == CMD_QUERY) |=> (state == ST_SCAN))
    else $error("query did not start a scan");

  a_scan_holds_occ: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (occ == $past(occ)))
    else $error("occupancy moved during a scan");

  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    scan_last |=> out_vld)
    else $error("scan ended without a result beat");

endmodule
